// ===== rtl/sws_pkg.sv =====
// shared types, constants and checksum helpers of the stop-and-wait sender
`default_nettype none
package sws_pkg;

    localparam int SWS_PAYLOAD_BYTES = 20;
    localparam int SWS_QUEUE_DEPTH   = 4;
    localparam int ACK_SHIFT         = 5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // input commands
    localparam logic [1:0] CMD_MSG  = 2'd0;
    localparam logic [1:0] CMD_PKT  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic OUT_PACKET  = 1'b0;
    localparam logic OUT_REFUSED = 1'b1;

    // register map, word index taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic {
        JOB_SEND   = 1'b0,
        JOB_REFUSE = 1'b1
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        bank;
        logic [31:0] seq;
        logic [31:0] chk;
    } t_job;

    // one checksum step: xor in the sign-extended byte, then acc ^= acc << 1
    function automatic logic [31:0] mix(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] t;
        t = acc ^ {{24{b[7]}}, b};
        return t ^ {t[30:0], 1'b0};
    endfunction

    // n steps of x ^= x << 1, i.e. x times (1+z)^n over gf(2) mod z^32;
    // term z^k is present when the bits of k are a subset of the bits of n
    function automatic logic [31:0] tpow(input logic [31:0] x, input int n);
        logic [31:0] r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if ((k & n) == k) begin
                r = r ^ (x << k);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sws_in_if.sv =====
// input channel: command, data byte and incoming packet header
`default_nettype none
interface sws_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [7:0]  data_byte;
    logic signed [31:0] pkt_seqnum;
    logic signed [31:0] pkt_acknum;
    logic signed [31:0] pkt_checksum;

    modport source (
        output valid, command, data_byte, pkt_seqnum, pkt_acknum, pkt_checksum,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, pkt_seqnum, pkt_acknum, pkt_checksum,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/sws_out_if.sv =====
// output channel: transmitted packet bytes and refusals
`default_nettype none
interface sws_out_if;
    logic               valid;
    logic               ready;
    logic               out_kind;
    logic signed [7:0]  out_byte;
    logic signed [31:0] out_seqnum;
    logic signed [31:0] out_checksum;
    logic               out_last;

    modport source (
        output valid, out_kind, out_byte, out_seqnum, out_checksum, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_byte, out_seqnum, out_checksum, out_last,
        output ready
    );
    modport monitor (
        input valid, ready, out_kind, out_byte, out_seqnum, out_checksum, out_last
    );
endinterface
`default_nettype wire

// ===== rtl/sws_front.sv =====
// front end: classifies input transactions, keeps protocol state, queues transmitter jobs
`default_nettype none
module sws_front #(
    parameter int PAYLOAD_BYTES = sws_pkg::SWS_PAYLOAD_BYTES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    sws_in_if.sink                                      i_msg,
    input  wire logic [15:0]                            i_timeout,
    input  wire logic                                   i_q_full,
    input  wire logic                                   i_drained,
    output logic                                        o_push,
    output sws_pkg::t_job                               o_job,
    output logic                                        o_wr_en,
    output logic [$clog2(2*PAYLOAD_BYTES)-1:0]          o_wr_addr,
    output logic [7:0]                                  o_wr_data
);
    import sws_pkg::*;

    localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int AW = $clog2(2*PAYLOAD_BYTES);
    localparam logic [IW-1:0] LAST = IW'(PAYLOAD_BYTES - 1);

    logic [IW-1:0] r_msg_pos, n_msg_pos;
    logic [IW-1:0] r_rx_pos, n_rx_pos;
    logic [31:0]   r_msg_acc, n_msg_acc;
    logic [31:0]   r_rx_acc, n_rx_acc;
    logic [31:0]   r_sent_next, n_sent_next;
    logic          r_busy, n_busy;
    logic          r_sav_bank, n_sav_bank;
    logic [31:0]   r_sav_seq, n_sav_seq;
    logic [31:0]   r_sav_chk, n_sav_chk;
    logic [15:0]   r_timer_cnt, n_timer_cnt;
    logic          r_timer_on, n_timer_on;
    logic          r_hold, n_hold;

    logic          accept;
    logic [31:0]   msg_mix;
    logic [31:0]   rx_base;
    logic [31:0]   rx_mix;
    logic [16:0]   tick_sum;
    t_job          resend_job;

    assign i_msg.ready = !i_q_full && !r_hold;
    assign accept      = i_msg.valid && i_msg.ready;

    assign msg_mix  = mix((r_msg_pos == '0) ? 32'd0 : r_msg_acc, i_msg.data_byte);
    assign rx_base  = (r_rx_pos == '0)
                    ? ($unsigned(i_msg.pkt_seqnum) ^ ($unsigned(i_msg.pkt_acknum) << ACK_SHIFT))
                    : r_rx_acc;
    assign rx_mix   = mix(rx_base, i_msg.data_byte);
    assign tick_sum = {1'b0, r_timer_cnt} + 17'd1;

    always_comb begin
        resend_job.kind = JOB_SEND;
        resend_job.bank = r_sav_bank;
        resend_job.seq  = r_sav_seq;
        resend_job.chk  = r_sav_chk;
    end

    always_comb begin
        n_msg_pos   = r_msg_pos;
        n_rx_pos    = r_rx_pos;
        n_msg_acc   = r_msg_acc;
        n_rx_acc    = r_rx_acc;
        n_sent_next = r_sent_next;
        n_busy      = r_busy;
        n_sav_bank  = r_sav_bank;
        n_sav_seq   = r_sav_seq;
        n_sav_chk   = r_sav_chk;
        n_timer_cnt = r_timer_cnt;
        n_timer_on  = r_timer_on;
        n_hold      = r_hold && !i_drained;
        o_push      = 1'b0;
        o_job       = resend_job;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_sav_bank ? AW'(r_msg_pos) : AW'(PAYLOAD_BYTES) + AW'(r_msg_pos);
        o_wr_data   = i_msg.data_byte;

        if (accept) begin
            case (i_msg.command)
                CMD_MSG: begin
                    // bytes go to the staging bank, the one not holding the saved packet
                    o_wr_en   = 1'b1;
                    n_msg_acc = msg_mix;
                    if (r_msg_pos == LAST) begin
                        n_msg_pos = '0;
                        if (r_busy) begin
                            o_push      = 1'b1;
                            o_job.kind  = JOB_REFUSE;
                            o_job.seq   = '0;
                            o_job.chk   = '0;
                        end else begin
                            n_busy      = 1'b1;
                            n_sav_bank  = !r_sav_bank;
                            n_sav_seq   = r_sent_next;
                            n_sav_chk   = tpow(r_sent_next, PAYLOAD_BYTES) ^ msg_mix;
                            n_timer_cnt = '0;
                            n_timer_on  = 1'b1;
                            n_hold      = 1'b1;
                            o_push      = 1'b1;
                            o_job.kind  = JOB_SEND;
                            o_job.bank  = !r_sav_bank;
                            o_job.seq   = r_sent_next;
                            o_job.chk   = tpow(r_sent_next, PAYLOAD_BYTES) ^ msg_mix;
                        end
                    end else begin
                        n_msg_pos = r_msg_pos + IW'(1);
                    end
                end
                CMD_PKT: begin
                    n_rx_acc = rx_mix;
                    if (r_rx_pos == LAST) begin
                        n_rx_pos = '0;
                        if (($unsigned(i_msg.pkt_checksum) == rx_mix)
                                && (i_msg.pkt_acknum == '0)) begin
                            if ($unsigned(i_msg.pkt_seqnum) == r_sent_next) begin
                                n_timer_on  = 1'b0;
                                n_timer_cnt = '0;
                                n_busy      = 1'b0;
                                n_sent_next = r_sent_next + 32'd1;
                            end
                        end else begin
                            o_push = 1'b1;
                        end
                    end else begin
                        n_rx_pos = r_rx_pos + IW'(1);
                    end
                end
                CMD_TICK: begin
                    if (r_timer_on) begin
                        if (tick_sum >= {1'b0, i_timeout}) begin
                            n_timer_cnt = '0;
                            o_push      = 1'b1;
                        end else begin
                            n_timer_cnt = tick_sum[15:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_pos   <= '0;
            r_rx_pos    <= '0;
            r_sent_next <= 32'd1;
            r_busy      <= 1'b0;
            r_sav_bank  <= 1'b0;
            r_timer_cnt <= '0;
            r_timer_on  <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            r_msg_pos   <= n_msg_pos;
            r_rx_pos    <= n_rx_pos;
            r_sent_next <= n_sent_next;
            r_busy      <= n_busy;
            r_sav_bank  <= n_sav_bank;
            r_timer_cnt <= n_timer_cnt;
            r_timer_on  <= n_timer_on;
            r_hold      <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg_acc <= n_msg_acc;
        r_rx_acc  <= n_rx_acc;
        r_sav_seq <= n_sav_seq;
        r_sav_chk <= n_sav_chk;
    end

endmodule
`default_nettype wire

// ===== rtl/sws_queue.sv =====
// short job queue between front end and transmitter
`default_nettype none
module sws_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sws_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output sws_pkg::t_job      o_job,
    output logic               o_empty
);
    import sws_pkg::*;

    localparam int PW = (SWS_QUEUE_DEPTH > 1) ? $clog2(SWS_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(SWS_QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(SWS_QUEUE_DEPTH - 1);

    t_job          r_slot [SWS_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(SWS_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sws_back.sv =====
// transmitter: packet store and byte-by-byte output of queued jobs
`default_nettype none
module sws_back #(
    parameter int PAYLOAD_BYTES = sws_pkg::SWS_PAYLOAD_BYTES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_wr_en,
    input  wire logic [$clog2(2*PAYLOAD_BYTES)-1:0]     i_wr_addr,
    input  wire logic [7:0]                             i_wr_data,
    input  wire logic                                   i_empty,
    input  wire sws_pkg::t_job                          i_job,
    output logic                                        o_pop,
    output logic                                        o_idle,
    sws_out_if.source                                   o_res
);
    import sws_pkg::*;

    localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int AW = $clog2(2*PAYLOAD_BYTES);
    localparam logic [IW-1:0] LAST = IW'(PAYLOAD_BYTES - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_REFUSE
    } t_state;

    // two banks: one holds the saved packet, the other stages the next message
    logic [7:0]    r_mem [2*PAYLOAD_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;

    t_state        r_state;
    logic [IW-1:0] r_idx;
    t_job          r_job;
    logic          r_ov;
    logic          r_out_kind;
    logic [7:0]    r_out_byte;
    logic [31:0]   r_out_seq;
    logic [31:0]   r_out_chk;
    logic          r_out_last;
    logic          out_free;
    logic          out_load;

    assign rd_addr  = r_job.bank ? AW'(PAYLOAD_BYTES) + AW'(r_idx) : AW'(r_idx);
    assign out_free = !r_ov || o_res.ready;
    assign out_load = out_free && ((r_state == B_LOAD) || (r_state == B_REFUSE));
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_idle   = (r_state == B_IDLE);

    assign o_res.valid        = r_ov;
    assign o_res.out_kind     = r_out_kind;
    assign o_res.out_byte     = r_out_byte;
    assign o_res.out_seqnum   = r_out_seq;
    assign o_res.out_checksum = r_out_chk;
    assign o_res.out_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output register fills on a load, empties on a transaction
            r_ov <= out_load || (r_ov && !o_res.ready);
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_state <= (i_job.kind == JOB_REFUSE) ? B_REFUSE : B_READ;
                    end
                end
                B_READ: begin
                    r_state <= B_LOAD;
                end
                B_LOAD: begin
                    if (out_free) begin
                        r_out_kind <= OUT_PACKET;
                        r_out_byte <= r_rd_data;
                        r_out_seq  <= r_job.seq;
                        r_out_chk  <= r_job.chk;
                        r_out_last <= (r_idx == LAST);
                        if (r_idx == LAST) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= B_READ;
                        end
                    end
                end
                B_REFUSE: begin
                    if (out_free) begin
                        r_out_kind <= OUT_REFUSED;
                        r_out_byte <= '0;
                        r_out_seq  <= '0;
                        r_out_chk  <= '0;
                        r_out_last <= 1'b1;
                        r_state    <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_sender.sv =====
// top level of the stop-and-wait arq sender: config register, front end, job queue, transmitter
// timing: with the job queue empty a packet job goes through dispatch, store read and output
//   load before its first byte is valid, a refusal through dispatch and output load
// output: bytes one at a time, each a store read then an output load, held on a stall; input
//   one per cycle while the queue has room, held after a new packet is stored until it is sent
// reset: synchronous, active low; clears control state, packet store needs no clearing pass
`default_nettype none
module stop_and_wait_sender #(
    parameter int PAYLOAD_BYTES = sws_pkg::SWS_PAYLOAD_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sws_in_if.sink           i_msg,
    sws_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sws_pkg::*;

    localparam int AW = $clog2(2*PAYLOAD_BYTES);

    // timeout register, to be written only while nothing is in flight; the block does not enforce this
    logic [15:0]   r_timeout;

    // front end to queue
    logic          push;
    t_job          push_job;
    logic          q_full;

    // queue to transmitter
    logic          pop;
    t_job          head_job;
    logic          q_empty;
    logic          back_idle;

    // message bytes into the packet store
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign pready = 1'b1;

    // apb write completes on the access phase; paddr[2] selects the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
            r_timeout <= pwdata[15:0];
        end
    end

    // read back, unmapped word reads as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = {16'd0, r_timeout};
        end
    end

    // front end: message staging, incoming packet checks, retransmit timer
    sws_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_msg     (i_msg),
        .i_timeout (r_timeout),
        .i_q_full  (q_full),
        .i_drained (q_empty && back_idle),
        .o_push    (push),
        .o_job     (push_job),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // jobs waiting for the transmitter: send, resend or refusal
    sws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    // transmitter: streams the saved packet or a refusal through the output register
    sws_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_empty   (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_idle    (back_idle),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// ===== rtl/sws_checker.sv =====
// port-level checks of the stop-and-wait sender and their binding to the top level
`default_nettype none
module sws_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_byte,
    input  wire logic [31:0] i_seq,
    input  wire logic [31:0] i_chk,
    input  wire logic        i_last,
    input  wire logic        pready
);
    import sws_pkg::*;

    // a refusal is a single transaction with empty fields
    a_refuse_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == OUT_REFUSED)) |->
        (i_last && (i_byte == '0) && (i_seq == '0) && (i_chk == '0)))
        else $error("refusal with nonzero fields or without last");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
        (i_valid && $stable(i_kind) && $stable(i_byte) && $stable(i_seq)
         && $stable(i_chk) && $stable(i_last)))
        else $error("output changed while stalled");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

    // config port never inserts wait states
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind stop_and_wait_sender sws_checker u_sws_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_kind  (o_res.out_kind),
    .i_byte  (o_res.out_byte),
    .i_seq   (o_res.out_seqnum),
    .i_chk   (o_res.out_checksum),
    .i_last  (o_res.out_last),
    .pready  (pready)
);
`default_nettype wire
